// File: hw/rtl/graph_m_coloring_search_unit_assert.svh
// ---------------------------------------------------------------------------
// graph_m_coloring_search_unit_assert
// Assertion macros for the m-coloring search unit.
// ---------------------------------------------------------------------------
`ifndef GRAPH_M_COLORING_SEARCH_UNIT_ASSERT_SVH
`define GRAPH_M_COLORING_SEARCH_UNIT_ASSERT_SVH

// Implication checked on every edge outside reset.
`define GMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gmc_pkg.sv
// ---------------------------------------------------------------------------
// gmc_pkg
// Shared types and constants of the m-coloring search unit.
// ---------------------------------------------------------------------------
package gmc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned VtxW     = $clog2(MaxNodes);
  localparam int unsigned CntW     = VtxW + 1;
  localparam int unsigned ColorW   = 7;
  localparam int unsigned ColorCap = 64;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpEdge  = 2'd1;
  localparam logic [1:0] OpSolve = 2'd2;

  localparam logic RegVertexCount = 1'b0;
  localparam logic RegColorLimit  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StEdgeRd,
    StEdgeWr,
    StVtxRd,
    StScan,
    StScanWait,
    StEmitRd,
    StEmit,
    StFail
  } state_e;

endpackage

// File: hw/rtl/gmc_ram.sv
// ---------------------------------------------------------------------------
// gmc_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module gmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/graph_m_coloring_search_unit.sv
// ---------------------------------------------------------------------------
// graph_m_coloring_search_unit
// Loads an undirected graph into an adjacency RAM and m-colors it by
// depth-first backtracking, reporting one color per vertex or a failure beat.
// ---------------------------------------------------------------------------
// Usage: commands arrive as beats on the s_axis channel (tdata holds op,
// vertex_a and vertex_b). Clear wipes the adjacency RAM.
// Add edge is a read-modify-write of two rows. Solve runs the
// backtracking search: for each trial color the search scans every vertex
// one per cycle through the color RAM, checking the neighbors of the
// current vertex; a whole solve is data dependent and can be exponential
// in the worst case. Results leave on m_axis: one beat per vertex on
// success, tlast on the final one, or a single failure beat. The block
// takes one command at a time; s_axis_tready is low while a command is in
// progress. A stalled receiver holds the result beat and the rest of the
// run waits for it; once the run is done, new commands are taken while
// the last beat still waits. After reset the adjacency RAM is swept to
// zero while s_axis_tready stays low; configuration writes are taken at
// any time the block is idle.
// ---------------------------------------------------------------------------
`include "graph_m_coloring_search_unit_assert.svh"

module graph_m_coloring_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // op[1:0], vertex_a[7:2], vertex_b[13:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // vertex_index[5:0], vertex_color[12:6]
  output logic        m_axis_tuser,  // solved
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i
);

  localparam int unsigned VW = gmc_pkg::VtxW;
  localparam int unsigned NW = gmc_pkg::CntW;
  localparam int unsigned CW = gmc_pkg::ColorW;
  localparam int unsigned MN = gmc_pkg::MaxNodes;

  gmc_pkg::state_e state_q, state_d;

  logic [6:0]    vcount_q, climit_q;
  logic [NW-1:0] n_q, n_d;
  logic [CW-1:0] m_q, m_d;
  logic [VW-1:0] v_q, v_d, a_q, a_d, b_q, b_d;
  logic [NW-1:0] i_q, i_d;
  logic [CW-1:0] c_q, c_d;
  logic [MN-1:0] row_q, row_d;
  logic          pass_q, pass_d;
  logic          phase_q, phase_d;
  // Colors valid only for vertices below the scan frontier; others read 0.
  logic [MN-1:0] cvalid_q, cvalid_d;
  logic          ovalid_q, ovalid_d;
  logic [VW-1:0] oidx_q, oidx_d;
  logic [CW-1:0] ocol_q, ocol_d;
  logic          osolved_q, osolved_d, olast_q, olast_d;

  logic          adj_we, col_we;
  logic [VW-1:0] adj_waddr, adj_raddr, col_waddr, col_raddr;
  logic [MN-1:0] adj_wdata, adj_rdata;
  logic [CW-1:0] col_wdata, col_rdata;

  gmc_ram #(.Width(MN), .Depth(MN)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );
  gmc_ram #(.Width(CW), .Depth(MN)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .raddr_i(col_raddr), .rdata_o(col_rdata)
  );

  logic s_fire, m_free;
  logic [1:0]    in_op;
  logic [VW-1:0] in_a, in_b;
  logic [VW-1:0] iv;
  logic [CW-1:0] col_eff;
  assign in_op  = s_axis_tdata[1:0];
  assign in_a   = s_axis_tdata[7:2];
  assign in_b   = s_axis_tdata[13:8];
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_free = !ovalid_q || m_axis_tready;
  assign iv     = i_q[VW-1:0];
  // Index of the color RAM read issued last cycle.
  logic [VW-1:0] prev_iv_q;
  assign col_eff = cvalid_q[prev_iv_q] ? col_rdata : '0;

  // A trial ends when all n vertices are checked or no color is left.
  logic scan_hit, scan_over, scan_end;
  assign scan_hit  = row_q[prev_iv_q] && (col_eff == c_q);
  assign scan_over = c_q > m_q;
  assign scan_end  = (i_q == n_q) || scan_over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 7'd4;
      climit_q <= 7'd3;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gmc_pkg::RegVertexCount) vcount_q <= cfg_wdata_i;
      else                                      climit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gmc_pkg::StClear;
      i_q      <= '0;
      cvalid_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      cvalid_q <= cvalid_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; m_q <= m_d; v_q <= v_d; a_q <= a_d; b_q <= b_d;
    c_q <= c_d; row_q <= row_d; pass_q <= pass_d; phase_q <= phase_d;
    oidx_q <= oidx_d; ocol_q <= ocol_d; osolved_q <= osolved_d; olast_q <= olast_d;
    prev_iv_q <= col_raddr;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gmc_pkg::StIdle: begin
        if (s_fire) begin
          case (in_op)
            gmc_pkg::OpClear: state_d = gmc_pkg::StClear;
            gmc_pkg::OpEdge:  state_d = gmc_pkg::StEdgeRd;
            gmc_pkg::OpSolve: state_d = gmc_pkg::StVtxRd;
            default:          state_d = gmc_pkg::StIdle;
          endcase
        end
      end
      gmc_pkg::StClear:
        if (i_q == NW'(MN - 1)) state_d = gmc_pkg::StIdle;
      gmc_pkg::StEdgeRd: state_d = gmc_pkg::StEdgeWr;
      gmc_pkg::StEdgeWr:
        if (phase_q) state_d = gmc_pkg::StIdle;
        else         state_d = gmc_pkg::StEdgeRd;
      gmc_pkg::StVtxRd: state_d = gmc_pkg::StScanWait;
      gmc_pkg::StScanWait: state_d = gmc_pkg::StScan;
      gmc_pkg::StScan: begin
        if (scan_end) begin
          if (pass_q && !scan_hit && !scan_over) begin
            if (NW'(v_q) + NW'(1) >= n_q) state_d = gmc_pkg::StEmitRd;
            else                          state_d = gmc_pkg::StVtxRd;
          end else if (c_q < m_q) begin
            state_d = gmc_pkg::StScan;
          end else if (v_q != '0) begin
            state_d = gmc_pkg::StVtxRd;
          end else begin
            state_d = gmc_pkg::StFail;
          end
        end
      end
      gmc_pkg::StEmitRd: state_d = gmc_pkg::StEmit;
      gmc_pkg::StEmit:
        if (m_free && i_q == n_q - NW'(1)) state_d = gmc_pkg::StIdle;
        else if (m_free)                   state_d = gmc_pkg::StEmitRd;
      gmc_pkg::StFail:
        if (m_free) state_d = gmc_pkg::StIdle;
      default: state_d = gmc_pkg::StIdle;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    n_d = n_q; m_d = m_q; v_d = v_q; a_d = a_q; b_d = b_q; i_d = i_q;
    c_d = c_q; row_d = row_q; pass_d = pass_q; phase_d = phase_q;
    cvalid_d = cvalid_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    oidx_d = oidx_q; ocol_d = ocol_q; osolved_d = osolved_q; olast_d = olast_q;
    adj_we = 1'b0; adj_waddr = a_q; adj_wdata = '0; adj_raddr = a_q;
    col_we = 1'b0; col_waddr = v_q; col_wdata = c_q; col_raddr = iv;
    s_axis_tready = 1'b0;
    case (state_q)
      gmc_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        i_d = '0;
        phase_d = 1'b0;
        a_d = in_a; b_d = in_b;
        v_d = '0;
        if (s_fire && in_op == gmc_pkg::OpClear) cvalid_d = '0;
        if (s_fire && in_op == gmc_pkg::OpSolve) begin
          cvalid_d = '0;
          n_d = (vcount_q == 7'd0) ? NW'(1)
              : (vcount_q > 7'(MN)) ? NW'(MN) : vcount_q[NW-1:0];
          m_d = (climit_q > 7'(gmc_pkg::ColorCap)) ? CW'(gmc_pkg::ColorCap) : climit_q;
        end
      end
      gmc_pkg::StClear: begin
        adj_we = 1'b1; adj_waddr = iv; adj_wdata = '0;
        i_d = i_q + NW'(1);
      end
      gmc_pkg::StEdgeRd: adj_raddr = phase_q ? b_q : a_q;
      gmc_pkg::StEdgeWr: begin
        adj_we = 1'b1;
        adj_waddr = phase_q ? b_q : a_q;
        adj_wdata = adj_rdata | (MN'(1) << (phase_q ? a_q : b_q));
        phase_d = 1'b1;
      end
      gmc_pkg::StVtxRd: begin
        // Fetch row and old color of v.
        adj_raddr = v_q; col_raddr = v_q;
        i_d = '0;
      end
      gmc_pkg::StScanWait: begin
        row_d = adj_rdata;
        c_d = (cvalid_q[v_q] ? col_rdata : '0) + CW'(1);
        cvalid_d[v_q] = 1'b0;
        pass_d = 1'b1;
        col_raddr = '0;
        i_d = NW'(1);
      end
      gmc_pkg::StScan: begin
        // One vertex per cycle; the color of vertex i-1 arrives now.
        col_raddr = iv;
        if (!scan_end) begin
          if (scan_hit) pass_d = 1'b0;
          i_d = i_q + NW'(1);
        end else if (pass_q && !scan_hit && !scan_over) begin
          col_we = 1'b1; col_waddr = v_q; col_wdata = c_q;
          cvalid_d[v_q] = 1'b1;
          i_d = '0;
          if (NW'(v_q) + NW'(1) < n_q) v_d = v_q + VW'(1);
        end else if (c_q < m_q) begin
          // Try the next color of the same vertex.
          c_d = c_q + CW'(1);
          pass_d = 1'b1;
          col_raddr = '0;
          i_d = NW'(1);
        end else if (v_q != '0) begin
          v_d = v_q - VW'(1);
          i_d = '0;
        end
      end
      gmc_pkg::StEmitRd: col_raddr = iv;
      gmc_pkg::StEmit: begin
        if (m_free) begin
          ovalid_d = 1'b1;
          oidx_d = iv;
          ocol_d = col_eff;
          osolved_d = 1'b1;
          olast_d = (i_q == n_q - NW'(1));
          i_d = i_q + NW'(1);
        end
        col_raddr = iv;
      end
      gmc_pkg::StFail: begin
        if (m_free) begin
          ovalid_d = 1'b1;
          oidx_d = '0; ocol_d = '0; osolved_d = 1'b0; olast_d = 1'b1;
          cvalid_d = '0;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, ocol_q, oidx_q};
  assign m_axis_tuser  = osolved_q;
  assign m_axis_tlast  = olast_q;

  `GMC_ASSERT_IMP(a_no_accept_busy, s_fire, state_q == gmc_pkg::StIdle,
                  "command accepted while busy")
  `GMC_ASSERT_IMP(a_fail_shape, m_axis_tvalid && !m_axis_tuser,
                  m_axis_tlast && m_axis_tdata == 16'd0, "malformed failure beat")
  `GMC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                   "result beat dropped under stall")

endmodule
